FILE: src/brm_pkg.sv
// Shared constants, types and helper functions for the radix-2 Booth multiplier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package brm_pkg;

  localparam int WIDTH = 16;
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;
  localparam int PROD_W = 2 * WIDTH;
  localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_PASS = CNT_W'(WIDTH - 1);

  typedef logic [WIDTH-1:0] operand_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } brm_cmd_t;

  typedef struct packed {
    logic last_pass;
  } brm_status_t;

  // Sign-extends a 16-bit input and keeps its low WIDTH bits.
  function automatic operand_t to_operand(input logic [IN_W-1:0] v);
    operand_t r;
    for (int i = 0; i < WIDTH; i++) begin
      r[i] = (i < IN_W) ? v[i] : v[IN_W-1];
    end
    return r;
  endfunction

  // Sign-extends or truncates the full product to the output width.
  function automatic logic [OUT_W-1:0] fit_product(input logic [PROD_W-1:0] p);
    logic [OUT_W-1:0] r;
    for (int i = 0; i < OUT_W; i++) begin
      r[i] = (i < PROD_W) ? p[i] : p[PROD_W-1];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/booth_radix2_multiplier_unit.sv
// Top level of the radix-2 Booth signed multiplier.
// Instantiates brm_controller and brm_datapath; depends on brm_pkg.
//
// The unit multiplies two signed 16-bit operands, taken as WIDTH-bit two's
// complement values, and returns the signed product sign-extended or
// truncated to 32 bits. A transaction is accepted while the unit is idle,
// after which the datapath performs WIDTH Booth add-or-subtract and shift
// passes, one pass per cycle unless the final pass stalls; the last pass
// writes the result register directly. A finished product waits in its own
// register, so the next transaction can be accepted while it is still
// pending; the final pass stalls only if the previous product has not yet
// been taken.
`default_nettype none

module booth_radix2_multiplier_unit import brm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   multiplier,
  input  wire logic [IN_W-1:0]   multiplicand,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       product
);

  brm_cmd_t    cmd;
  brm_status_t status;

  brm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  brm_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .multiplier   (multiplier),
    .multiplicand (multiplicand),
    .product      (product)
  );

endmodule

`default_nettype wire

FILE: src/brm_datapath.sv
// Datapath of the Booth multiplier: accumulator, multiplier shift register,
// pass counter and result register. Depends on brm_pkg.
`default_nettype none

module brm_datapath import brm_pkg::*; (
  input  wire logic              clk,
  input  wire brm_cmd_t          cmd,
  output brm_status_t            status,
  input  wire logic [IN_W-1:0]   multiplier,
  input  wire logic [IN_W-1:0]   multiplicand,
  output logic [OUT_W-1:0]       product
);

  operand_t         accumulator;
  operand_t         multiplier_shift;
  logic             prior_bit;
  operand_t         held_multiplicand;
  logic [CNT_W-1:0] pass_count;

  operand_t         sum;
  operand_t         accumulator_next;
  operand_t         multiplier_shift_next;
  logic             low_bit;

  always_comb begin
    low_bit = multiplier_shift[0];
    if (low_bit && !prior_bit) begin
      sum = accumulator - held_multiplicand;
    end else if (!low_bit && prior_bit) begin
      sum = accumulator + held_multiplicand;
    end else begin
      sum = accumulator;
    end
    accumulator_next      = {sum[WIDTH-1], sum[WIDTH-1:1]};
    multiplier_shift_next = {sum[0], multiplier_shift[WIDTH-1:1]};
  end

  assign status.last_pass = (pass_count == LAST_PASS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accumulator       <= '0;
      multiplier_shift  <= to_operand(multiplier);
      prior_bit         <= 1'b0;
      held_multiplicand <= to_operand(multiplicand);
      pass_count        <= '0;
    end else if (cmd.step) begin
      accumulator      <= accumulator_next;
      multiplier_shift <= multiplier_shift_next;
      prior_bit        <= low_bit;
      pass_count       <= pass_count + 1'b1;
    end
    if (cmd.capture) begin
      product <= fit_product({accumulator_next, multiplier_shift_next});
    end
  end

endmodule

`default_nettype wire

FILE: src/brm_controller.sv
// Controller of the Booth multiplier: sequences load and passes and owns the
// handshake flags of both channels. Depends on brm_pkg.
`default_nettype none

module brm_controller import brm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire brm_status_t status,
  output brm_cmd_t         cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.step    = (state == ST_BUSY) && (!status.last_pass || out_free);
    cmd.capture = (state == ST_BUSY) && status.last_pass && out_free;

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cmd.capture) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/brm_checker.sv
// Port-level assertions for the Booth multiplier, bound to its top level.
// Depends on brm_pkg and booth_radix2_multiplier_unit.
`default_nettype none

module brm_checker import brm_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] product
);

  // A pending result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product))
    else $error("pending product changed or was dropped");

  // Once a transaction is accepted, the unit is busy with it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a product is in progress");

  // A new result appears only once the multiplier is free again.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_valid && in_ready))
    else $error("result appeared without a completed product");

endmodule

bind booth_radix2_multiplier_unit brm_checker u_brm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .product   (product)
);

`default_nettype wire
